@@ rtl/sps_pkg.sv @@
package sps_pkg;

    localparam int POS_W      = 16;
    localparam int ACTION_W   = 3;
    localparam int STATE_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [POS_W-1:0] HOME_RESET  = 16'd2000;
    localparam logic [POS_W-1:0] DELAY_RESET = 16'd10;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK  = 3'd0,
        ACT_GOTO  = 3'd1,
        ACT_HOME  = 3'd2,
        ACT_SWEEP = 3'd3,
        ACT_STOP  = 3'd4
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HOME_POSITION = 2'd0,
        CFG_STEP_DELAY    = 2'd1
    } cfg_index_t;

    typedef enum logic [STATE_W-1:0] {
        ST_POSITION  = 4'd0,
        ST_JUDGE     = 4'd1,
        ST_UP        = 4'd2,
        ST_DOWN      = 4'd3,
        ST_WAIT      = 4'd4,
        ST_STOP      = 4'd5,
        ST_HOME      = 4'd6,
        ST_AUTO      = 4'd7,
        ST_AUTO_WAIT = 4'd8
    } mode_t;

endpackage

@@ rtl/sps_if.sv @@
interface sps_cmd_if;
    import sps_pkg::*;
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [POS_W-1:0]    target;
    logic [POS_W-1:0]    sweep_min;
    logic [POS_W-1:0]    sweep_max;

    modport source (output valid, action, target, sweep_min, sweep_max, input ready);
    modport sink   (input valid, action, target, sweep_min, sweep_max, output ready);
endinterface

interface sps_res_if;
    import sps_pkg::*;
    logic               valid;
    logic               ready;
    logic [POS_W-1:0]   position;
    logic               position_written;
    logic [STATE_W-1:0] run_state;

    modport source (output valid, position, position_written, run_state, input ready);
    modport sink   (input valid, position, position_written, run_state, output ready);
endinterface

interface sps_cfg_if;
    import sps_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wdata;

    modport source (output valid, reg_index, wdata, input ready);
    modport sink   (input valid, reg_index, wdata, output ready);
endinterface

@@ rtl/servo_position_stepper.sv @@
// servo_position_stepper: one command or tick word in, one result word out.
// The result is registered: it is valid in the cycle after the word is accepted.
// Throughput: 1 word per cycle; input stalls only while an untaken result
// sits in the result register and the sink holds ready low.
// Reset (rst_n low, async): mode STOP, position/target/bounds/wait count 0,
// sweep upward, home_position 2000, step_delay 10, no result pending.
module servo_position_stepper
    import sps_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    sps_cmd_if.sink   cmd,
    sps_res_if.source res,
    sps_cfg_if.sink   cfg
);

    // Configuration registers; the user must write them only while idle (not enforced here).
    logic [POS_W-1:0] home_position_reg;
    logic [POS_W-1:0] step_delay_reg;

    // Machine state
    mode_t            mode_reg,       mode_next;
    logic [POS_W-1:0] cur_pos_reg,    cur_pos_next;
    logic [POS_W-1:0] tgt_pos_reg,    tgt_pos_next;
    logic [POS_W-1:0] wait_cnt_reg,   wait_cnt_next;
    logic             sweep_down_reg, sweep_down_next;
    logic [POS_W-1:0] low_bound_reg,  low_bound_next;
    logic [POS_W-1:0] high_bound_reg, high_bound_next;

    // Result register
    logic               res_valid_reg;
    logic [POS_W-1:0]   res_pos_reg;
    logic               res_wr_reg;
    logic [STATE_W-1:0] res_state_reg;
    logic               wrote_next;

    logic               accept;
    action_t            act;
    logic               is_tick;
    logic [POS_W-1:0]   pos_inc;
    logic [POS_W-1:0]   pos_dec;
    logic [POS_W-1:0]   auto_pos;
    logic [POS_W-1:0]   wait_inc;
    logic               wait_done;

    // Result register doubles as the skid: take a new word whenever the
    // slot is empty or is being drained this cycle.
    assign cmd.ready = !res_valid_reg || res.ready;
    assign accept    = cmd.valid && cmd.ready;
    assign cfg.ready = 1'b1;

    assign act     = action_t'(cmd.action);
    // Unused action codes fall through to a plain tick.
    assign is_tick = !(act == ACT_GOTO || act == ACT_HOME ||
                       act == ACT_SWEEP || act == ACT_STOP);

    assign pos_inc   = cur_pos_reg + 16'd1;
    assign pos_dec   = cur_pos_reg - 16'd1;
    assign auto_pos  = sweep_down_reg ? pos_dec : pos_inc;
    // Wait ends once the incremented count passes step_delay; at the
    // largest delay the counter wraps and the wait never ends.
    assign wait_inc  = wait_cnt_reg + 16'd1;
    assign wait_done = wait_inc > step_delay_reg;

    // Next mode
    always_comb
    begin
        mode_next = mode_reg;
        case (act)
            ACT_GOTO:  mode_next = ST_POSITION;
            ACT_HOME:  mode_next = ST_HOME;
            ACT_SWEEP: mode_next = ST_AUTO;
            ACT_STOP:  mode_next = ST_STOP;
            default:
            begin
                case (mode_reg)
                    ST_POSITION: mode_next = ST_JUDGE;
                    ST_JUDGE:
                    begin
                        if (cur_pos_reg < tgt_pos_reg)
                            mode_next = ST_UP;
                        else if (cur_pos_reg > tgt_pos_reg)
                            mode_next = ST_DOWN;
                        else
                            mode_next = ST_STOP;
                    end
                    ST_UP:        mode_next = (pos_inc == tgt_pos_reg) ? ST_STOP : ST_WAIT;
                    ST_DOWN:      mode_next = (pos_dec == tgt_pos_reg) ? ST_STOP : ST_WAIT;
                    ST_WAIT:      mode_next = wait_done ? ST_JUDGE : ST_WAIT;
                    ST_HOME:      mode_next = ST_STOP;
                    ST_AUTO:      mode_next = ST_AUTO_WAIT;
                    ST_AUTO_WAIT: mode_next = wait_done ? ST_AUTO : ST_AUTO_WAIT;
                    default:      mode_next = mode_reg;
                endcase
            end
        endcase
    end

    // Datapath and write strobe
    always_comb
    begin
        cur_pos_next    = cur_pos_reg;
        tgt_pos_next    = tgt_pos_reg;
        wait_cnt_next   = wait_cnt_reg;
        sweep_down_next = sweep_down_reg;
        low_bound_next  = low_bound_reg;
        high_bound_next = high_bound_reg;
        wrote_next      = 1'b0;

        if (act == ACT_GOTO)
            tgt_pos_next = cmd.target;
        if (act == ACT_SWEEP)
        begin
            low_bound_next  = cmd.sweep_min;
            high_bound_next = cmd.sweep_max;
        end

        if (is_tick)
        begin
            case (mode_reg)
                ST_UP:
                begin
                    cur_pos_next = pos_inc;
                    wrote_next   = 1'b1;
                end
                ST_DOWN:
                begin
                    cur_pos_next = pos_dec;
                    wrote_next   = 1'b1;
                end
                ST_WAIT, ST_AUTO_WAIT:
                    wait_cnt_next = wait_done ? '0 : wait_inc;
                ST_HOME:
                begin
                    cur_pos_next = home_position_reg;
                    wrote_next   = 1'b1;
                end
                ST_AUTO:
                begin
                    cur_pos_next = auto_pos;
                    wrote_next   = 1'b1;
                    // reverse at the bounds
                    if (!sweep_down_reg && (auto_pos > high_bound_reg))
                        sweep_down_next = 1'b1;
                    else if (sweep_down_reg && (auto_pos < low_bound_reg))
                        sweep_down_next = 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            home_position_reg <= HOME_RESET;
            step_delay_reg    <= DELAY_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg_index_t'(cfg.reg_index))
                CFG_HOME_POSITION: home_position_reg <= cfg.wdata;
                CFG_STEP_DELAY:    step_delay_reg    <= cfg.wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= ST_STOP;
            cur_pos_reg    <= '0;
            tgt_pos_reg    <= '0;
            wait_cnt_reg   <= '0;
            sweep_down_reg <= 1'b0;
            low_bound_reg  <= '0;
            high_bound_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg       <= mode_next;
            cur_pos_reg    <= cur_pos_next;
            tgt_pos_reg    <= tgt_pos_next;
            wait_cnt_reg   <= wait_cnt_next;
            sweep_down_reg <= sweep_down_next;
            low_bound_reg  <= low_bound_next;
            high_bound_reg <= high_bound_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (accept)
            res_valid_reg <= 1'b1;
        else if (res.ready)
            res_valid_reg <= 1'b0;
    end

    // Result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_pos_reg   <= cur_pos_next;
            res_wr_reg    <= wrote_next;
            res_state_reg <= mode_next;
        end
    end

    assign res.valid            = res_valid_reg;
    assign res.position         = res_pos_reg;
    assign res.position_written = res_wr_reg;
    assign res.run_state        = res_state_reg;

endmodule
